@@ sv/lrs_pkg.sv @@
package lrs_pkg;

   // Fixed widths of the transaction fields.
   localparam int KEY_W = 30;
   localparam int TAG_W = 16;
   localparam int POS_W = 10;
   localparam int REC_W = KEY_W + TAG_W;

   // Defaults for the top-level parameters.
   localparam int DEF_MAX_RECORDS = 1024;
   localparam int DEF_KEY_BITS    = 30;
   localparam int DEF_DIGIT_BITS  = 6;
   localparam int DEF_TAG_BITS    = 16;

   // Request action codes.
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // Sort sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_COUNT,
      ST_PREFIX,
      ST_SCATTER
   } sort_state_type;

   // Which of the two ping-pong record stores is meant.
   typedef enum logic {
      STORE_A,
      STORE_B
   } store_sel_type;

   // Commands to the bucket unit.
   typedef struct packed {
      logic clear;   // write zero to the addressed bucket
      logic inc;     // fetch the addressed bucket and increment it
      logic pfx;     // read the addressed bucket for the prefix sweep
   } bkt_op_type;

   // Status from the bucket unit.
   typedef struct packed {
      logic idle;        // no fetch or prefix operation in flight
      logic inc_valid;   // fetched value is presented this cycle
   } bkt_status_type;

   // Commands to the record banks.
   typedef struct packed {
      logic          load_we;   // store a loaded record into store A
      logic          src_re;    // read the pass source store
      store_sel_type src_sel;   // source store of the current pass
      logic          dst_we;    // write a scattered record to the other store
   } bank_op_type;

endpackage

@@ sv/lrs_bucket_unit.sv @@
module lrs_bucket_unit #(
   parameter int DIGIT_BITS  = lrs_pkg::DEF_DIGIT_BITS,
   parameter int MAX_RECORDS = lrs_pkg::DEF_MAX_RECORDS,
   localparam int CNT_W      = $clog2(MAX_RECORDS + 1),
   localparam int BUCKETS    = 1 << DIGIT_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lrs_pkg::bkt_op_type    op,
   input  logic [DIGIT_BITS-1:0]  op_addr,
   output lrs_pkg::bkt_status_type status,
   output logic [CNT_W-1:0]       inc_old
);

   // Bucket counter memory, one read and one write port, read data registered.
   logic [CNT_W-1:0]      bucket_mem [BUCKETS];
   logic [CNT_W-1:0]      rd_data_ff;

   logic                  st_inc_ff, st_inc_in;
   logic                  st_pfx_ff, st_pfx_in;
   logic [DIGIT_BITS-1:0] st_addr_ff, st_addr_in;

   logic                  fw_valid_ff, fw_valid_in;
   logic [DIGIT_BITS-1:0] fw_addr_ff, fw_addr_in;
   logic [CNT_W-1:0]      fw_data_ff, fw_data_in;

   logic [CNT_W-1:0]      run_ff, run_in;

   logic                  wr_en;
   logic [DIGIT_BITS-1:0] wr_addr;
   logic [CNT_W-1:0]      wr_data;
   logic [CNT_W-1:0]      old_value;

   // The memory returns the old contents when read and written at one address in a cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bucket_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= bucket_mem[op_addr];
   end

   // A fetch right behind an increment of the same bucket takes the incremented value.
   always_comb begin
      if (fw_valid_ff && (fw_addr_ff == st_addr_ff)) begin
         old_value = fw_data_ff;
      end else begin
         old_value = rd_data_ff;
      end
   end

   // Write port: clearing sweep, then increments, then prefix offsets.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = op_addr;
      wr_data = '0;
      run_in  = run_ff;
      priority if (op.clear) begin
         wr_en   = 1'b1;
         wr_addr = op_addr;
         wr_data = '0;
         run_in  = '0;
      end else if (st_inc_ff) begin
         wr_en   = 1'b1;
         wr_addr = st_addr_ff;
         wr_data = old_value + 1'b1;
      end else if (st_pfx_ff) begin
         wr_en   = 1'b1;
         wr_addr = st_addr_ff;
         wr_data = run_ff;
         run_in  = run_ff + rd_data_ff;
      end else begin
         wr_en   = 1'b0;
      end
   end

   // Stage and forwarding register inputs.
   always_comb begin
      st_inc_in   = op.inc;
      st_pfx_in   = op.pfx;
      st_addr_in  = op_addr;
      fw_valid_in = st_inc_ff;
      fw_addr_in  = st_addr_ff;
      fw_data_in  = old_value + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_inc_ff   <= 1'b0;
         st_pfx_ff   <= 1'b0;
         fw_valid_ff <= 1'b0;
      end else begin
         st_inc_ff   <= st_inc_in;
         st_pfx_ff   <= st_pfx_in;
         fw_valid_ff <= fw_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      st_addr_ff <= st_addr_in;
      fw_addr_ff <= fw_addr_in;
      fw_data_ff <= fw_data_in;
      run_ff     <= run_in;
   end

   assign inc_old          = old_value;
   assign status.inc_valid = st_inc_ff;
   assign status.idle      = !st_inc_ff && !st_pfx_ff;

endmodule

@@ sv/lrs_record_banks.sv @@
module lrs_record_banks #(
   parameter int   DEPTH     = lrs_pkg::DEF_MAX_RECORDS,
   parameter logic HOST_ON_B = 1'b1,
   localparam int  ADDR_W    = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  lrs_pkg::bank_op_type       op,
   input  logic [ADDR_W-1:0]          load_addr,
   input  logic [lrs_pkg::REC_W-1:0]  load_rec,
   input  logic [ADDR_W-1:0]          src_addr,
   input  logic [ADDR_W-1:0]          dst_addr,
   input  logic [lrs_pkg::REC_W-1:0]  dst_rec,
   input  logic [ADDR_W-1:0]          host_addr,
   output logic [lrs_pkg::REC_W-1:0]  src_rec,
   output logic [lrs_pkg::REC_W-1:0]  host_rec
);

   // Two ping-pong record stores with registered read data.
   logic [lrs_pkg::REC_W-1:0] store_a_mem [DEPTH];
   logic [lrs_pkg::REC_W-1:0] store_b_mem [DEPTH];
   logic [lrs_pkg::REC_W-1:0] rd_a_ff, rd_b_ff;
   lrs_pkg::store_sel_type    src_sel_ff, src_sel_in;

   logic                      we_a, we_b;
   logic [ADDR_W-1:0]         wa_a, ra_a, ra_b;
   logic [lrs_pkg::REC_W-1:0] wd_a;
   logic                      dst_is_a;

   // Port steering: loads and odd-pass scatters land in A, even-pass scatters in B.
   always_comb begin
      dst_is_a = (op.src_sel == lrs_pkg::STORE_B);
      we_a     = op.load_we || (op.dst_we && dst_is_a);
      we_b     = op.dst_we && !dst_is_a;
      wa_a     = op.load_we ? load_addr : dst_addr;
      wd_a     = op.load_we ? load_rec  : dst_rec;
      ra_a     = (op.src_re && (op.src_sel == lrs_pkg::STORE_A)) ? src_addr : host_addr;
      ra_b     = (op.src_re && (op.src_sel == lrs_pkg::STORE_B)) ? src_addr : host_addr;
      src_sel_in = op.src_sel;
   end

   always_ff @(posedge clock) begin
      if (we_a) begin
         store_a_mem[wa_a] <= wd_a;
      end
      rd_a_ff <= store_a_mem[ra_a];
   end

   always_ff @(posedge clock) begin
      if (we_b) begin
         store_b_mem[dst_addr] <= dst_rec;
      end
      rd_b_ff <= store_b_mem[ra_b];
   end

   always_ff @(posedge clock) begin
      src_sel_ff <= src_sel_in;
   end

   assign src_rec  = (src_sel_ff == lrs_pkg::STORE_B) ? rd_b_ff : rd_a_ff;
   assign host_rec = HOST_ON_B ? rd_b_ff : rd_a_ff;

endmodule

@@ sv/lsd_radix_key_sorter_core.sv @@
// Stable LSD radix sorter for keyed records.
// Request channel: a transaction is taken at a rising edge with start high and busy low.
// A load (req_action low) stores one key and tag if the store is not full; a load with
// req_final_record high ends the set and starts the sort, during which busy stays high.
// A read (req_action high) returns the record at req_read_position on the rsp_ ports
// in the cycle after it is taken, for exactly one cycle, marked by rsp_valid; reads can be
// issued back to back. The receiver cannot stall, so nothing waits on the result side.
// The sort makes ceil(KEY_BITS / DIGIT_BITS) passes through the two record stores and
// the bucket memory, each pass made of a bucket clearing sweep, a counting stream over
// the source store, a prefix sweep and a scatter stream, the streams bound by one record
// read per cycle.
// Reset clears the loaded count, the done and overflow flags and the sequencer; the
// record stores are not cleared and only written entries are ever returned as valid.
module lsd_radix_key_sorter_core #(
   parameter int MAX_RECORDS = lrs_pkg::DEF_MAX_RECORDS,
   parameter int KEY_BITS    = lrs_pkg::DEF_KEY_BITS,
   parameter int DIGIT_BITS  = lrs_pkg::DEF_DIGIT_BITS,
   parameter int TAG_BITS    = lrs_pkg::DEF_TAG_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_action,
   input  logic [lrs_pkg::KEY_W-1:0] req_sort_key,
   input  logic [lrs_pkg::TAG_W-1:0] req_payload_tag,
   input  logic                      req_final_record,
   input  logic [lrs_pkg::POS_W-1:0] req_read_position,
   output logic                      rsp_valid,
   output logic [lrs_pkg::KEY_W-1:0] rsp_sorted_key,
   output logic [lrs_pkg::TAG_W-1:0] rsp_sorted_tag,
   output logic                      rsp_entry_valid,
   output logic                      rsp_overflow_seen
);

   localparam int AW       = $clog2(MAX_RECORDS);
   localparam int CNT_W    = $clog2(MAX_RECORDS + 1);
   localparam int PASSES   = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int PASS_W   = (PASSES > 1) ? $clog2(PASSES) : 1;
   localparam int EXT_W    = (PASSES * DIGIT_BITS > lrs_pkg::KEY_W) ?
                             PASSES * DIGIT_BITS : lrs_pkg::KEY_W;
   localparam int SH_W     = $clog2(EXT_W + 1);
   localparam int CMP_W    = (CNT_W > lrs_pkg::POS_W) ? CNT_W : lrs_pkg::POS_W;
   localparam int PW       = (AW > lrs_pkg::POS_W) ? AW : lrs_pkg::POS_W;
   localparam int TAG_KEEP = (TAG_BITS < lrs_pkg::TAG_W) ? TAG_BITS : lrs_pkg::TAG_W;
   localparam logic HOST_ON_B = (PASSES % 2) == 1;
   localparam logic [EXT_W-1:0] SORT_MASK = {EXT_W{1'b1}} >> (EXT_W - KEY_BITS);
   localparam logic [lrs_pkg::TAG_W-1:0] TAG_MASK =
      {lrs_pkg::TAG_W{1'b1}} >> (lrs_pkg::TAG_W - TAG_KEEP);

   lrs_pkg::sort_state_type state_ff, state_in;

   logic [PASS_W-1:0]       pass_ff, pass_in;
   logic [SH_W-1:0]         shift_ff, shift_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [DIGIT_BITS:0]     bidx_ff, bidx_in;
   logic                    s1_valid_ff, s1_valid_in;
   logic [lrs_pkg::REC_W-1:0] s2_rec_ff, s2_rec_in;
   logic [CNT_W-1:0]        loaded_count_ff, loaded_count_in;
   logic                    sort_done_ff, sort_done_in;
   logic                    overflow_ff, overflow_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   logic                    accept, load_acc, read_acc;
   logic [CNT_W-1:0]        eff_count;
   logic                    store_full;
   logic [lrs_pkg::REC_W-1:0] load_rec;
   logic                    idx_active, stream_done, bidx_top, clear_last, last_pass;
   logic [EXT_W-1:0]        key_ext, digit_word;
   logic [DIGIT_BITS-1:0]   digit, bkt_addr;
   logic [PW-1:0]           pos_ext;
   logic [AW-1:0]           host_addr;

   lrs_pkg::bkt_op_type     bkt_op;
   lrs_pkg::bkt_status_type bkt_status;
   logic [CNT_W-1:0]        bkt_old;
   lrs_pkg::bank_op_type    bank_op;
   logic [lrs_pkg::REC_W-1:0] src_rec, host_rec;

   // Request decode and load bookkeeping.
   always_comb begin
      accept     = start && (state_ff == lrs_pkg::ST_IDLE);
      load_acc   = accept && (req_action == lrs_pkg::ACT_LOAD);
      read_acc   = accept && (req_action == lrs_pkg::ACT_READ);
      eff_count  = sort_done_ff ? '0 : loaded_count_ff;
      store_full = (eff_count == CNT_W'(MAX_RECORDS));
      load_rec   = {req_sort_key, req_payload_tag & TAG_MASK};
      pos_ext    = PW'(req_read_position);
      host_addr  = pos_ext[AW-1:0];
   end

   // Digit of the record coming out of the source store.
   always_comb begin
      key_ext    = EXT_W'(src_rec[lrs_pkg::REC_W-1:lrs_pkg::TAG_W]);
      digit_word = (key_ext & SORT_MASK) >> shift_ff;
      digit      = digit_word[DIGIT_BITS-1:0];
   end

   // Phase conditions.
   always_comb begin
      idx_active  = (idx_ff < loaded_count_ff);
      stream_done = !idx_active && !s1_valid_ff && bkt_status.idle;
      bidx_top    = bidx_ff[DIGIT_BITS];
      clear_last  = (bidx_ff[DIGIT_BITS-1:0] == {DIGIT_BITS{1'b1}});
      last_pass   = (pass_ff == PASS_W'(PASSES - 1));
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lrs_pkg::ST_IDLE: begin
            if (load_acc && req_final_record) begin
               state_in = lrs_pkg::ST_CLEAR;
            end
         end
         lrs_pkg::ST_CLEAR: begin
            if (clear_last) begin
               state_in = lrs_pkg::ST_COUNT;
            end
         end
         lrs_pkg::ST_COUNT: begin
            if (stream_done) begin
               state_in = lrs_pkg::ST_PREFIX;
            end
         end
         lrs_pkg::ST_PREFIX: begin
            if (bidx_top && bkt_status.idle) begin
               state_in = lrs_pkg::ST_SCATTER;
            end
         end
         lrs_pkg::ST_SCATTER: begin
            if (stream_done) begin
               state_in = last_pass ? lrs_pkg::ST_IDLE : lrs_pkg::ST_CLEAR;
            end
         end
         default: begin
            state_in = lrs_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs to the bucket unit and the record banks.
   always_comb begin
      bkt_op.clear    = (state_ff == lrs_pkg::ST_CLEAR);
      bkt_op.inc      = s1_valid_ff;
      bkt_op.pfx      = (state_ff == lrs_pkg::ST_PREFIX) && !bidx_top;
      bkt_addr        = s1_valid_ff ? digit : bidx_ff[DIGIT_BITS-1:0];
      bank_op.load_we = load_acc && !store_full;
      bank_op.src_re  = ((state_ff == lrs_pkg::ST_COUNT) ||
                         (state_ff == lrs_pkg::ST_SCATTER)) && idx_active;
      bank_op.src_sel = pass_ff[0] ? lrs_pkg::STORE_B : lrs_pkg::STORE_A;
      bank_op.dst_we  = (state_ff == lrs_pkg::ST_SCATTER) && bkt_status.inc_valid;
   end

   // Counters of the passes and sweeps.
   always_comb begin
      idx_in      = idx_ff;
      bidx_in     = bidx_ff;
      pass_in     = pass_ff;
      shift_in    = shift_ff;
      s1_valid_in = bank_op.src_re;
      s2_rec_in   = src_rec;
      unique case (state_ff)
         lrs_pkg::ST_IDLE: begin
            idx_in   = '0;
            bidx_in  = '0;
            pass_in  = '0;
            shift_in = '0;
         end
         lrs_pkg::ST_CLEAR: begin
            idx_in  = '0;
            bidx_in = bidx_ff + 1'b1;
         end
         lrs_pkg::ST_COUNT: begin
            bidx_in = '0;
            if (bank_op.src_re) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         lrs_pkg::ST_PREFIX: begin
            idx_in = '0;
            if (!bidx_top) begin
               bidx_in = bidx_ff + 1'b1;
            end
         end
         lrs_pkg::ST_SCATTER: begin
            bidx_in = '0;
            if (bank_op.src_re) begin
               idx_in = idx_ff + 1'b1;
            end
            if (stream_done && !last_pass) begin
               idx_in   = '0;
               pass_in  = pass_ff + 1'b1;
               shift_in = shift_ff + SH_W'(DIGIT_BITS);
            end
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   // Set bookkeeping and the read response.
   always_comb begin
      loaded_count_in = loaded_count_ff;
      sort_done_in    = sort_done_ff;
      overflow_in     = overflow_ff;
      if (load_acc) begin
         sort_done_in    = 1'b0;
         overflow_in     = (sort_done_ff ? 1'b0 : overflow_ff) || store_full;
         loaded_count_in = store_full ? eff_count : eff_count + 1'b1;
      end
      if ((state_ff == lrs_pkg::ST_SCATTER) && stream_done && last_pass) begin
         sort_done_in = 1'b1;
      end
      rsp_valid_in = read_acc;
      rsp_hit_in   = sort_done_ff &&
                     (CMP_W'(req_read_position) < CMP_W'(loaded_count_ff));
      rsp_ovf_in   = overflow_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= lrs_pkg::ST_IDLE;
         pass_ff         <= '0;
         shift_ff        <= '0;
         idx_ff          <= '0;
         bidx_ff         <= '0;
         s1_valid_ff     <= 1'b0;
         loaded_count_ff <= '0;
         sort_done_ff    <= 1'b0;
         overflow_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pass_ff         <= pass_in;
         shift_ff        <= shift_in;
         idx_ff          <= idx_in;
         bidx_ff         <= bidx_in;
         s1_valid_ff     <= s1_valid_in;
         loaded_count_ff <= loaded_count_in;
         sort_done_ff    <= sort_done_in;
         overflow_ff     <= overflow_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_rec_ff  <= s2_rec_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   // Bucket counters: counting, prefix offsets and scatter positions.
   lrs_bucket_unit #(
      .DIGIT_BITS  (DIGIT_BITS),
      .MAX_RECORDS (MAX_RECORDS)
   ) u_bucket (
      .clock   (clock),
      .reset   (reset),
      .op      (bkt_op),
      .op_addr (bkt_addr),
      .status  (bkt_status),
      .inc_old (bkt_old)
   );

   // Ping-pong record stores.
   lrs_record_banks #(
      .DEPTH     (MAX_RECORDS),
      .HOST_ON_B (HOST_ON_B)
   ) u_banks (
      .clock     (clock),
      .op        (bank_op),
      .load_addr (eff_count[AW-1:0]),
      .load_rec  (load_rec),
      .src_addr  (idx_ff[AW-1:0]),
      .dst_addr  (bkt_old[AW-1:0]),
      .dst_rec   (s2_rec_ff),
      .host_addr (host_addr),
      .src_rec   (src_rec),
      .host_rec  (host_rec)
   );

   // Result transaction.
   assign busy              = (state_ff != lrs_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_entry_valid   = rsp_hit_ff;
   assign rsp_overflow_seen = rsp_ovf_ff;
   assign rsp_sorted_key    = rsp_hit_ff ? host_rec[lrs_pkg::REC_W-1:lrs_pkg::TAG_W] : '0;
   assign rsp_sorted_tag    = rsp_hit_ff ? host_rec[lrs_pkg::TAG_W-1:0] : '0;

   // A scattered record always lands inside the loaded range.
   a_scatter_in_range: assert property (@(posedge clock) disable iff (reset)
      bank_op.dst_we |-> (bkt_old < loaded_count_ff))
      else $error("scatter position beyond loaded count");

   // A response follows only a read taken in the previous cycle.
   a_rsp_follows_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && (req_action == lrs_pkg::ACT_READ)))
      else $error("response without a read request");

   // A valid entry is only reported for a finished sort.
   a_hit_after_sort: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_entry_valid) |-> sort_done_ff)
      else $error("valid entry before the sort finished");

   // The set size holds still while the sort runs.
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff != lrs_pkg::ST_IDLE) |=> $stable(loaded_count_ff))
      else $error("loaded count changed during the sort");

   // Leaving the last scatter marks the sort done.
   a_done_at_end: assert property (@(posedge clock) disable iff (reset)
      (($past(state_ff) == lrs_pkg::ST_SCATTER) && (state_ff == lrs_pkg::ST_IDLE))
      |-> sort_done_ff)
      else $error("sort ended without setting done");

endmodule

@@ tb/tb_lsd_radix_key_sorter_core.sv @@
module tb_lsd_radix_key_sorter_core;

   localparam int KEY_W       = lrs_pkg::KEY_W;
   localparam int TAG_W       = lrs_pkg::TAG_W;
   localparam int POS_W       = lrs_pkg::POS_W;
   localparam int CAPACITY    = lrs_pkg::DEF_MAX_RECORDS;
   localparam int SORT_BITS   = lrs_pkg::DEF_KEY_BITS;
   localparam int DIGIT_W     = lrs_pkg::DEF_DIGIT_BITS;
   localparam int NUM_BUCKETS = 1 << DIGIT_W;
   localparam int NUM_PASSES  = (SORT_BITS + DIGIT_W - 1) / DIGIT_W;
   localparam bit [KEY_W-1:0] SORT_MASK = {KEY_W{1'b1}} >> (KEY_W - SORT_BITS);
   localparam int RANDOM_ITEMS = 600;
   localparam int LIMIT_CYCLES = 500000;

   // One stored record: key and the tag that travels with it.
   typedef struct packed {
      bit [KEY_W-1:0] key;
      bit [TAG_W-1:0] tag;
   } record_type;

   // What one read transaction should return.
   typedef struct packed {
      bit [KEY_W-1:0] key;
      bit [TAG_W-1:0] tag;
      bit             entry_valid;
      bit             overflow;
   } read_reply_type;

   // Tracks the record set as the block should see it and the replies owed to reads.
   class sorted_record_tracker;
      record_type     loaded [CAPACITY];
      record_type     sorted [CAPACITY];
      int unsigned    loaded_count;
      bit             sort_done;
      bit             overflow_flag;
      read_reply_type replies_due [$];
      int unsigned    mismatches, checked, valid_hits;
      int unsigned    loads_taken, reads_taken, sets_sorted, dropped_loads;

      function new();
         loaded_count  = 0;
         sort_done     = 1'b0;
         overflow_flag = 1'b0;
         mismatches    = 0;
         checked       = 0;
         valid_hits    = 0;
         loads_taken   = 0;
         reads_taken   = 0;
         sets_sorted   = 0;
         dropped_loads = 0;
      endfunction

      function int unsigned digit_of(bit [KEY_W-1:0] key, int pass_idx);
         bit [KEY_W-1:0] sort_bits;
         sort_bits = key & SORT_MASK;
         return int'((sort_bits >> (pass_idx * DIGIT_W)) & (NUM_BUCKETS - 1));
      endfunction

      // Stable LSD radix sort of the loaded records, one counting pass per digit.
      function void radix_sort_set();
         record_type  src [CAPACITY];
         record_type  dst [CAPACITY];
         int unsigned bucket_total [NUM_BUCKETS];
         int unsigned next_slot [NUM_BUCKETS];
         int unsigned running, d;
         int          pass_idx, i, b;
         src = loaded;
         dst = loaded;
         for (pass_idx = 0; pass_idx < NUM_PASSES; pass_idx++) begin
            for (b = 0; b < NUM_BUCKETS; b++) begin
               bucket_total[b] = 0;
            end
            for (i = 0; i < loaded_count; i++) begin
               bucket_total[digit_of(src[i].key, pass_idx)]++;
            end
            running = 0;
            for (b = 0; b < NUM_BUCKETS; b++) begin
               next_slot[b] = running;
               running += bucket_total[b];
            end
            for (i = 0; i < loaded_count; i++) begin
               d = digit_of(src[i].key, pass_idx);
               dst[next_slot[d]] = src[i];
               next_slot[d]++;
            end
            src = dst;
         end
         sorted    = src;
         sort_done = 1'b1;
         sets_sorted++;
      endfunction

      // Apply one accepted transaction; a read leaves the reply it is owed.
      function void note_request(logic action, logic [KEY_W-1:0] key,
                                 logic [TAG_W-1:0] tag, logic last,
                                 logic [POS_W-1:0] pos);
         read_reply_type reply;
         bit             hit;
         if (action == lrs_pkg::ACT_LOAD) begin
            loads_taken++;
            // A load after a finished sort opens a new set.
            if (sort_done) begin
               loaded_count  = 0;
               overflow_flag = 1'b0;
               sort_done     = 1'b0;
            end
            if (loaded_count < CAPACITY) begin
               loaded[loaded_count] = '{key: key, tag: tag};
               loaded_count++;
            end else begin
               overflow_flag = 1'b1;
               dropped_loads++;
            end
            if (last) begin
               radix_sort_set();
            end
         end else begin
            reads_taken++;
            hit               = sort_done && (pos < loaded_count);
            reply.key         = hit ? sorted[pos].key : '0;
            reply.tag         = hit ? sorted[pos].tag : '0;
            reply.entry_valid = hit;
            reply.overflow    = overflow_flag;
            replies_due       = {replies_due, reply};
         end
      endfunction

      // Prints one line per mismatch and counts every one.
      task report(string what, logic [63:0] want, logic [63:0] got);
         mismatches++;
         $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
      endtask

      // Compare one reply against the oldest read still owed one.
      task check_reply(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                       logic entry_valid, logic overflow);
         read_reply_type want;
         if (replies_due.size() == 0) begin
            report("reply with no read outstanding", 64'd0, 64'd1);
            return;
         end
         want = replies_due.pop_front();
         checked++;
         if (want.entry_valid) begin
            valid_hits++;
         end
         if (key !== want.key) begin
            report("sorted_key", 64'(want.key), 64'(key));
         end
         if (tag !== want.tag) begin
            report("sorted_tag", 64'(want.tag), 64'(tag));
         end
         if (entry_valid !== want.entry_valid) begin
            report("entry_valid", 64'(want.entry_valid), 64'(entry_valid));
         end
         if (overflow !== want.overflow) begin
            report("overflow_seen", 64'(want.overflow), 64'(overflow));
         end
      endtask
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic             req_action;
   logic [KEY_W-1:0] req_sort_key;
   logic [TAG_W-1:0] req_payload_tag;
   logic             req_final_record;
   logic [POS_W-1:0] req_read_position;
   logic             rsp_valid;
   logic [KEY_W-1:0] rsp_sorted_key;
   logic [TAG_W-1:0] rsp_sorted_tag;
   logic             rsp_entry_valid;
   logic             rsp_overflow_seen;

   sorted_record_tracker tracker;
   int unsigned          burst_left;
   int unsigned          items_sent;
   int unsigned          cycle_count;
   bit [KEY_W-1:0]       dup_pool [4];

   lsd_radix_key_sorter_core dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_sort_key      (req_sort_key),
      .req_payload_tag   (req_payload_tag),
      .req_final_record  (req_final_record),
      .req_read_position (req_read_position),
      .rsp_valid         (rsp_valid),
      .rsp_sorted_key    (rsp_sorted_key),
      .rsp_sorted_tag    (rsp_sorted_tag),
      .rsp_entry_valid   (rsp_entry_valid),
      .rsp_overflow_seen (rsp_overflow_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit, well above the slowest correct run.
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run limit of %0d cycles reached.", LIMIT_CYCLES);
      $display("TEST FAILED");
      $finish;
   end

   // Every reply is checked at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         tracker.check_reply(rsp_sorted_key, rsp_sorted_tag, rsp_entry_valid,
                             rsp_overflow_seen);
      end
   end

   // Drive one transaction in random bursts and wait until the block takes it.
   task automatic issue(logic action, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                        logic last, logic [POS_W-1:0] pos);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      start             <= 1'b1;
      req_action        <= action;
      req_sort_key      <= key;
      req_payload_tag   <= tag;
      req_final_record  <= last;
      req_read_position <= pos;
      do @(posedge clock); while (busy);
      tracker.note_request(action, key, tag, last, pos);
      items_sent++;
   endtask

   // Fields that a transaction does not use carry random noise.
   task automatic load_record(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag, logic last);
      issue(lrs_pkg::ACT_LOAD, key, tag, last, POS_W'($urandom));
   endtask

   task automatic read_at(logic [POS_W-1:0] pos);
      issue(lrs_pkg::ACT_READ, KEY_W'($urandom), TAG_W'($urandom), 1'($urandom), pos);
   endtask

   // Keys: fully random, drawn from a small pool of repeats, or digit by digit at extremes or random.
   function automatic bit [KEY_W-1:0] rand_key(int unsigned mode);
      bit [KEY_W-1:0] key;
      int             d;
      key = '0;
      case (mode)
         0: key = KEY_W'($urandom);
         1: key = dup_pool[$urandom_range(0, 3)];
         default: begin
            for (d = 0; d < NUM_PASSES; d++) begin
               case ($urandom_range(0, 2))
                  0: key[d*DIGIT_W +: DIGIT_W] = '0;
                  1: key[d*DIGIT_W +: DIGIT_W] = '1;
                  default: key[d*DIGIT_W +: DIGIT_W] = DIGIT_W'($urandom);
               endcase
            end
         end
      endcase
      return key;
   endfunction

   // Load a whole set; reads may slip in before the sort as noise.
   task automatic run_set(int unsigned size, bit allow_peek);
      int unsigned mode, i;
      mode = $urandom_range(0, 2);
      for (i = 0; i < 4; i++) begin
         dup_pool[i] = KEY_W'($urandom);
      end
      for (i = 0; i < size; i++) begin
         if (allow_peek && $urandom_range(0, 9) == 0) begin
            read_at(POS_W'($urandom));
         end
         load_record(rand_key(mode), TAG_W'($urandom), i == size - 1);
      end
   endtask

   // Reads mostly inside the set, some past its end, some anywhere.
   task automatic read_burst(int unsigned size, int unsigned count);
      int unsigned c, sel;
      logic [POS_W-1:0] pos;
      for (c = 0; c < count; c++) begin
         sel = $urandom_range(0, 9);
         if (sel < 8 && size > 0) begin
            pos = POS_W'($urandom_range(0, size - 1));
         end else if (sel == 8 && size < CAPACITY) begin
            pos = POS_W'($urandom_range(size, CAPACITY - 1));
         end else begin
            pos = POS_W'($urandom);
         end
         read_at(pos);
      end
   endtask

   initial begin
      int unsigned base, size, i;
      tracker           = new();
      burst_left        = 0;
      items_sent        = 0;
      reset             <= 1'b1;
      start             <= 1'b0;
      req_action        <= lrs_pkg::ACT_LOAD;
      req_sort_key      <= '0;
      req_payload_tag   <= '0;
      req_final_record  <= 1'b0;
      req_read_position <= '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reads before any sort return nothing valid.
      read_at(POS_W'(0));
      read_at('1);

      // A final load on an empty set sorts a set of one.
      load_record('0, '0, 1'b1);
      read_at(POS_W'(0));
      read_at(POS_W'(1));

      // Extreme keys and tags, with equal keys that must keep their load order.
      load_record('1, '1, 1'b0);
      load_record('0, TAG_W'(1), 1'b0);
      load_record('1, TAG_W'(2), 1'b0);
      load_record(KEY_W'(30'h2AAAAAAA), TAG_W'(16'h8000), 1'b0);
      load_record(KEY_W'(30'h15555555), TAG_W'(16'h7FFF), 1'b0);
      load_record(KEY_W'(30'h0000003F), TAG_W'(3), 1'b1);
      for (i = 0; i <= 6; i++) begin
         read_at(POS_W'(i));
      end

      // A load after a sort starts a new set; a read in between sees no sort.
      load_record(KEY_W'(30'h20000000), TAG_W'(16'hA5A5), 1'b0);
      read_at(POS_W'(0));
      load_record(KEY_W'(1), TAG_W'(16'h5A5A), 1'b1);
      read_at(POS_W'(1));

      // Random sets, mostly small, each followed by a burst of reads.
      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         size = ($urandom_range(0, 7) == 0) ? $urandom_range(49, 160)
                                            : $urandom_range(1, 48);
         run_set(size, 1'b1);
         read_burst(size, $urandom_range(2, (size < 38) ? size + 2 : 40));
      end

      // A last short set, read before and after its sort.
      load_record(rand_key(0), TAG_W'($urandom), 1'b0);
      read_at(POS_W'(0));
      load_record(rand_key(2), TAG_W'($urandom), 1'b1);
      read_burst(2, 4);

      @(negedge clock);
      start <= 1'b0;
      while (tracker.replies_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      $display("Covered %0d loads in %0d sorted sets (%0d dropped at capacity), %0d reads.",
               tracker.loads_taken, tracker.sets_sorted, tracker.dropped_loads,
               tracker.reads_taken);
      $display("Checked %0d replies, %0d of them valid entries; %0d mismatches.",
               tracker.checked, tracker.valid_hits, tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.replies_due.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
